>>> hw/rtl/dlpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpd_pkg: shared types and constants of the decimal length-prefixed deframer
// Phase codes, field widths and the result beat layout.
// ----------------------------------------------------------------------------
package dlpd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned LenW        = 28;
  localparam int unsigned DigitCntW   = 3;
  // Header digits per frame, 1 to 8 (digit counter wraps at 8).
  localparam int unsigned HeaderDigits = 8;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DISC   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] body_byte;
    logic [LenW-1:0]  body_length;
    logic             first_of_frame;
    logic             last_of_frame;
    logic             empty_frame;
    logic             disconnected;
  } result_t;

endpackage

>>> hw/rtl/decimal_length_prefixed_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_length_prefixed_deframer: ASCII decimal length-prefixed deframer
// Strips an eight-digit length header and passes the body out byte by byte.
// ----------------------------------------------------------------------------
// A result beat is registered: it enters the result register, or the skid
// entry while a held result waits in the result register.
// Throughput: one input beat per cycle while in_stall_o is low; the header/body
// update is a single registered pass (multiply-by-ten as two shifts and an add).
// A two-entry output stage (result register plus skid) keeps input flowing
// while a result waits; in_stall_o is high only when the skid entry is full.
// Reset (rst_ni, async, active low): header phase, counters cleared, outputs
// empty.
module decimal_length_prefixed_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [dlpd_pkg::ByteW-1:0] data_byte_i,
  input  logic                       link_error_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [dlpd_pkg::ByteW-1:0] body_byte_o,
  output logic [dlpd_pkg::LenW-1:0]  body_length_o,
  output logic                       first_of_frame_o,
  output logic                       last_of_frame_o,
  output logic                       empty_frame_o,
  output logic                       disconnected_o
);

  localparam logic [dlpd_pkg::DigitCntW-1:0] LastDigit =
    dlpd_pkg::DigitCntW'(dlpd_pkg::HeaderDigits - 1);

  // Frame state
  dlpd_pkg::phase_e                   phase_q, phase_d;
  logic [dlpd_pkg::DigitCntW-1:0]     digit_cnt_q, digit_cnt_d;
  logic [dlpd_pkg::LenW-1:0]          len_acc_q, len_acc_d;
  logic [dlpd_pkg::LenW-1:0]          remain_q, remain_d;
  logic [dlpd_pkg::LenW-1:0]          frame_len_q, frame_len_d;
  logic                               at_start_q, at_start_d;

  // Output stage: result register and skid entry
  dlpd_pkg::result_t                  out_q, out_d, skid_q, skid_d;
  logic                               out_valid_q, out_valid_d;
  logic                               skid_valid_q, skid_valid_d;

  dlpd_pkg::result_t                  res;
  logic                               res_valid;
  logic                               accept, pop;
  logic [dlpd_pkg::LenW-1:0]          acc_next;

  // Stall depends on registered state only, never on in_valid_i.
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_q && !out_stall_i;

  // acc * 10 + low nibble, truncated to the length width
  assign acc_next = (len_acc_q << 3) + (len_acc_q << 1)
                  + dlpd_pkg::LenW'(data_byte_i[3:0]);

  // --------------------------------------------------------------------------
  // Per-beat frame logic
  // --------------------------------------------------------------------------
  always_comb begin
    phase_d     = phase_q;
    digit_cnt_d = digit_cnt_q;
    len_acc_d   = len_acc_q;
    remain_d    = remain_q;
    frame_len_d = frame_len_q;
    at_start_d  = at_start_q;
    res         = '0;
    res_valid   = 1'b0;

    if (accept && phase_q != dlpd_pkg::PH_DISC) begin
      if (link_error_i) begin
        // drop any partial frame, report once, then go deaf until reset
        phase_d            = dlpd_pkg::PH_DISC;
        res.disconnected   = 1'b1;
        res_valid          = 1'b1;
      end else begin
        case (phase_q)
          dlpd_pkg::PH_BODY: begin
            res.body_byte      = data_byte_i;
            res.body_length    = frame_len_q;
            res.first_of_frame = at_start_q;
            res.last_of_frame  = (remain_q <= dlpd_pkg::LenW'(1));
            res_valid          = 1'b1;
            at_start_d         = 1'b0;
            if (res.last_of_frame) begin
              remain_d    = '0;
              phase_d     = dlpd_pkg::PH_HEADER;
              digit_cnt_d = '0;
              len_acc_d   = '0;
            end else begin
              remain_d = remain_q - dlpd_pkg::LenW'(1);
            end
          end
          default: begin
            // header phase; the unused code behaves the same
            phase_d     = dlpd_pkg::PH_HEADER;
            len_acc_d   = acc_next;
            digit_cnt_d = digit_cnt_q + dlpd_pkg::DigitCntW'(1);
            if (digit_cnt_q == LastDigit) begin
              digit_cnt_d = '0;
              len_acc_d   = '0;
              frame_len_d = acc_next;
              at_start_d  = 1'b1;
              remain_d    = acc_next;
              if (acc_next == '0) begin
                res.last_of_frame = 1'b1;
                res.empty_frame   = 1'b1;
                res_valid         = 1'b1;
              end else begin
                phase_d = dlpd_pkg::PH_BODY;
              end
            end
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid entry
  // --------------------------------------------------------------------------
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      // input is stalled here, so only drain
      if (pop) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || pop) begin
      out_d       = res;
      out_valid_d = res_valid;
    end else if (res_valid) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= dlpd_pkg::PH_HEADER;
      digit_cnt_q  <= '0;
      len_acc_q    <= '0;
      remain_q     <= '0;
      frame_len_q  <= '0;
      at_start_q   <= 1'b1;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      digit_cnt_q  <= digit_cnt_d;
      len_acc_q    <= len_acc_d;
      remain_q     <= remain_d;
      frame_len_q  <= frame_len_d;
      at_start_q   <= at_start_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_valid_q;
  assign body_byte_o      = out_q.body_byte;
  assign body_length_o    = out_q.body_length;
  assign first_of_frame_o = out_q.first_of_frame;
  assign last_of_frame_o  = out_q.last_of_frame;
  assign empty_frame_o    = out_q.empty_frame;
  assign disconnected_o   = out_q.disconnected;

`ifndef SYNTH
  // skid entry is only ever filled behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without result register");

  // disconnect is sticky until reset
  a_disc_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dlpd_pkg::PH_DISC |=> phase_q == dlpd_pkg::PH_DISC)
    else $error("left disconnected phase");

  // body phase always has bytes left to come
  a_body_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dlpd_pkg::PH_BODY |-> remain_q != '0)
    else $error("body phase with no bytes remaining");

  // an accepted error beat outside disconnect, with the result register empty, yields a disconnect beat next
  a_disc_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && link_error_i && phase_q != dlpd_pkg::PH_DISC && !out_valid_q
    |=> out_valid_o && disconnected_o)
    else $error("link error not reported");
`endif

endmodule
